### sv/ssd_pkg.sv
// ============================================================================
// ssd_pkg: shared constants and types for the six-digit display driver
// Digit count, field widths, limits, segment patterns and the divide constant.
// ============================================================================
`default_nettype none

package ssd_pkg;

    localparam int DIGITS  = 6;
    localparam int VALUE_W = 20;
    localparam int DP_W    = 3;
    localparam int SEG_W   = 8;
    localparam int BCD_W   = 4;

    localparam logic [VALUE_W-1:0] MAX_VALUE  = 20'd999999;
    localparam logic [DP_W-1:0]    MAX_DP     = 3'd5;
    localparam logic [SEG_W-1:0]   POINT_BIT  = 8'h80;
    // active-low select of the leftmost digit
    localparam logic [DIGITS-1:0]  SEL_FIRST  = 6'h3e;
    // floor(2^20 / 1000): quotient estimate is exact or one short
    localparam logic [10:0]        RECIP_1000 = 11'd1048;

    typedef logic [DIGITS-1:0][BCD_W-1:0] t_digits;
    typedef logic [DIGITS-1:0][SEG_W-1:0] t_segs;

    function automatic logic [SEG_W-1:0] seg_of(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0: s = 8'h3f;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5b;
            4'd3: s = 8'h4f;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6d;
            4'd6: s = 8'h7d;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7f;
            4'd9: s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### sv/ssd_value_if.sv
// ============================================================================
// ssd_value_if: input value channel
// Valid/ready channel carrying one value to be displayed.
// ============================================================================
`default_nettype none

interface ssd_value_if;
    logic                       valid;
    logic                       ready;
    logic [ssd_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### sv/ssd_digit_if.sv
// ============================================================================
// ssd_digit_if: digit result channel
// Valid/ready channel carrying one digit's segments and select.
// ============================================================================
`default_nettype none

interface ssd_digit_if;
    logic                        valid;
    logic                        ready;
    logic [ssd_pkg::SEG_W-1:0]   segments;
    logic [ssd_pkg::DIGITS-1:0]  digit_select;
    logic                        last;

    modport source (output valid, output segments, output digit_select, output last,
                    input ready);
    modport sink   (input valid, input segments, input digit_select, input last,
                    output ready);
endinterface

`default_nettype wire

### sv/ssd_cfg_if.sv
// ============================================================================
// ssd_cfg_if: configuration write channel
// Valid/ready channel carrying the decimal_places register value.
// ============================================================================
`default_nettype none

interface ssd_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ssd_pkg::DP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/ssd_bin2bcd.sv
// ============================================================================
// ssd_bin2bcd: pipelined binary to six-digit BCD converter
// Saturate, split by 1000 via reciprocal multiply, then split each half into
// hundreds, tens and units. Five register stages, common stall enable.
// ============================================================================
`default_nettype none

module ssd_bin2bcd (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_valid,
    input  wire  [ssd_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    output ssd_pkg::t_digits            o_digits
);
    import ssd_pkg::*;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: saturated value
    logic [VALUE_W-1:0] r_val1;
    // stage 2: reciprocal product
    logic [30:0]        r_prod2;
    logic [VALUE_W-1:0] r_val2;
    // stage 3: thousands and remainder
    logic [1:0][9:0]    r_part3;
    // stage 4: hundreds digit and remainder below 100, per half
    logic [1:0][3:0]    r_hund4;
    logic [1:0][6:0]    r_rem4;
    // stage 5: all digits
    t_digits            r_dig5;

    logic [30:0]        w_prod;
    logic [9:0]         w_qe;
    logic [10:0]        w_rem;
    logic [1:0][9:0]    n_part;
    logic [1:0][3:0]    n_hund;
    logic [1:0][6:0]    n_rem;
    t_digits            n_dig;

    always_comb begin
        w_prod = 31'(r_val1) * 31'(RECIP_1000);
    end

    always_comb begin
        w_qe  = r_prod2[29:20];
        w_rem = 11'(r_val2 - 20'(w_qe) * 20'd1000);
        if (w_rem >= 11'd1000) begin
            n_part[1] = w_qe + 10'd1;
            n_part[0] = 10'(w_rem - 11'd1000);
        end else begin
            n_part[1] = w_qe;
            n_part[0] = w_rem[9:0];
        end
    end

    always_comb begin
        logic [15:0] hp;
        for (int k = 0; k < 2; k++) begin
            hp        = 16'(r_part3[k]) * 16'd41;   // x*41>>12 == x/100 for x<1000
            n_hund[k] = hp[15:12];
            n_rem[k]  = 7'(r_part3[k] - 10'(hp[15:12]) * 10'd100);
        end
    end

    always_comb begin
        logic [14:0] tp;
        logic [3:0]  tens;
        for (int k = 0; k < 2; k++) begin
            tp   = 15'(r_rem4[k]) * 15'd205;        // r*205>>11 == r/10 for r<100
            tens = tp[14:11];
            n_dig[3*(1-k)]     = r_hund4[k];
            n_dig[3*(1-k) + 1] = tens;
            n_dig[3*(1-k) + 2] = 4'(r_rem4[k] - 7'(tens) * 7'd10);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val1  <= (i_value > MAX_VALUE) ? MAX_VALUE : i_value;
            r_prod2 <= w_prod;
            r_val2  <= r_val1;
            r_part3 <= n_part;
            r_hund4 <= n_hund;
            r_rem4  <= n_rem;
            r_dig5  <= n_dig;
        end
    end

    assign o_valid  = r_v5;
    assign o_digits = r_dig5;

endmodule

`default_nettype wire

### sv/ssd_encode.sv
// ============================================================================
// ssd_encode: digit to segment encoder
// Maps six BCD digits to segment patterns, places the decimal point and
// blanks leading zeros. One register stage.
// ============================================================================
`default_nettype none

module ssd_encode (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_valid,
    input  ssd_pkg::t_digits          i_digits,
    input  wire  [ssd_pkg::DP_W-1:0]  i_dp,
    output logic                      o_valid,
    output ssd_pkg::t_segs            o_segs
);
    import ssd_pkg::*;

    logic     r_v;
    t_segs    r_segs;
    t_segs    n_segs;

    logic [DP_W-1:0] w_dp;
    logic [2:0]      w_point_pos;   // 1-based, 0 when no point
    logic [2:0]      w_first_shown; // 1-based

    always_comb begin
        w_dp = (i_dp > MAX_DP) ? MAX_DP : i_dp;
        if (w_dp == '0) begin
            w_point_pos   = 3'd0;
            w_first_shown = 3'(DIGITS);
        end else begin
            w_point_pos   = 3'(DIGITS) - w_dp;
            w_first_shown = 3'(DIGITS) - w_dp;
        end
    end

    always_comb begin
        logic       leading;
        logic [2:0] pos;
        leading = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            pos = 3'(i + 1);
            if (i_digits[i] != '0) begin
                leading = 1'b0;
            end
            if (leading && pos < w_first_shown) begin
                n_segs[i] = '0;
            end else begin
                n_segs[i] = seg_of(i_digits[i]) | ((pos == w_point_pos) ? POINT_BIT : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_segs <= n_segs;
        end
    end

    assign o_valid = r_v;
    assign o_segs  = r_segs;

endmodule

`default_nettype wire

### sv/ssd_serial.sv
// ============================================================================
// ssd_serial: digit serializer
// Holds one encoded value and sends its six digits, leftmost first, one
// transfer per cycle while the result channel is ready.
// ============================================================================
`default_nettype none

module ssd_serial (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_load,
    input  ssd_pkg::t_segs  i_segs,
    output logic            o_take,
    ssd_digit_if.source     o_digit
);
    import ssd_pkg::*;

    logic              r_busy;
    t_segs             r_segs;
    logic [DIGITS-1:0] r_sel;

    logic w_last;
    logic w_xfer;

    assign w_last = ~r_sel[DIGITS-1];
    assign w_xfer = r_busy && o_digit.ready;
    assign o_take = !r_busy || (o_digit.ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (w_xfer && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_segs <= i_segs;
            r_sel  <= SEL_FIRST;
        end else if (w_xfer) begin
            r_segs <= t_segs'(r_segs >> SEG_W);
            r_sel  <= {r_sel[DIGITS-2:0], 1'b1};
        end
    end

    assign o_digit.valid        = r_busy;
    assign o_digit.segments     = r_segs[0];
    assign o_digit.digit_select = r_sel;
    assign o_digit.last         = w_last;

endmodule

`default_nettype wire

### sv/seven_segment_decimal_display.sv
// ============================================================================
// seven_segment_decimal_display: six-digit seven-segment decimal driver
// Converts a scaled value into six digit transfers with point and blanking.
// ============================================================================
// Each accepted value produces six transfers on the digit channel, leftmost
// digit first, one per cycle while the sink is ready; last marks the sixth.
// In steady state the value rate is set by the single output register sending
// one digit per cycle while the sink is ready, which loads the next value with
// the last digit's transfer; conversion runs in a six-stage pipeline (saturate,
// reciprocal multiply, divide correction, hundreds split, tens/units split,
// segment encode). Values above 999999 show as 999999. decimal_places above 5
// acts as 5; write it only while no value is in flight.
`default_nettype none

module seven_segment_decimal_display (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ssd_value_if.sink    i_value_ch,
    ssd_cfg_if.sink      i_cfg_ch,
    ssd_digit_if.source  o_digit_ch
);
    import ssd_pkg::*;

    logic [DP_W-1:0] r_dp;

    logic    w_en;
    logic    w_take;
    logic    w_bcd_valid;
    t_digits w_digits;
    logic    w_enc_valid;
    t_segs   w_segs;

    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp <= '0;
        end else if (i_cfg_ch.valid) begin
            r_dp <= i_cfg_ch.data;
        end
    end

    // pipeline advances unless the encoded value is waiting on the serializer
    assign w_en             = !w_enc_valid || w_take;
    assign i_value_ch.ready = w_en;

    ssd_bin2bcd u_bin2bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_value_ch.valid),
        .i_value  (i_value_ch.value),
        .o_valid  (w_bcd_valid),
        .o_digits (w_digits)
    );

    ssd_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_bcd_valid),
        .i_digits (w_digits),
        .i_dp     (r_dp),
        .o_valid  (w_enc_valid),
        .o_segs   (w_segs)
    );

    ssd_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_enc_valid && w_take),
        .i_segs  (w_segs),
        .o_take  (w_take),
        .o_digit (o_digit_ch)
    );

endmodule

`default_nettype wire
